/* sv/iuhp_pkg.sv */
package iuhp_pkg;

    // Result codes, in the order the checks are taken.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_LEN_MISM   = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NOT_IPV4   = 3'd3,
        ST_FRAGMENTED = 3'd4,
        ST_NOT_UDP    = 3'd5,
        ST_BAD_UDPLEN = 3'd6
    } t_status;

    localparam logic [15:0] FRAG_MASK     = 16'hBFFF;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [15:0] MAX_PKT_RESET = 16'd1500;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam int OUT_DATA_W = 152;

    // Header fields of one packet as captured so far.
    typedef struct packed {
        logic [7:0]  ver_ihl;
        logic [7:0]  tos;
        logic [15:0] total_len;
        logic [15:0] ident;
        logic [15:0] frag;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] udp_len;
        logic        udp_seen;
    } t_pkt_fields;

endpackage

/* sv/ipv4_udp_header_parser.sv */
// IPv4/UDP header parser. Throughput: one packet byte per clock, except that a
// last byte waits in the input register while the output register still holds
// an untaken verdict. The verdict is written from the input register into the
// output register once that register is free.
// Reset (i_rst_n low, synchronous) empties both registers, clears all packet
// state and sets the maximum packet length to 1500 bytes.
module ipv4_udp_header_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [15:0]                         i_cfg_wdata,   // max_packet_length
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] status, [34:3] src_address, [66:35] dst_address, [82:67] src_port,
    // [98:83] dst_port, [106:99] time_to_live, [114:107] type_of_service,
    // [130:115] identification, [146:131] payload_length, [151:147] zero
    output logic [iuhp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import iuhp_pkg::*;

    // Configuration register.
    logic [15:0] r_max_len;

    // Input register: one byte waiting to be folded into the packet state.
    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;

    // Packet state.
    logic [15:0] r_byte_count;
    logic [15:0] n_byte_count;
    t_pkt_fields r_fields;
    t_pkt_fields n_fields;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        out_free;
    logic        proc_go;
    logic [15:0] pos;
    logic [15:0] hdr_len;
    logic [2:0]  udp_off;
    logic        in_udp_hdr;
    logic [3:0]  ihl;
    t_status     verdict;
    logic [15:0] payload_len;

    // A byte that is not the last one never needs the output register, so it
    // is folded in even while a verdict waits to be taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc_go       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || proc_go;

    assign pos     = r_byte_count;
    assign ihl     = r_fields.ver_ihl[3:0];
    assign hdr_len = {10'd0, ihl, 2'b00};
    assign udp_off = pos[2:0] - hdr_len[2:0];
    assign in_udp_hdr = (ihl >= MIN_IHL) && (pos >= hdr_len)
                        && (pos < hdr_len + UDP_HDR_BYTES);

    // Place the current byte into the field it belongs to. The IP header sits
    // at fixed offsets; the UDP header follows at ihl*4, which is always past
    // the fixed part once ihl is at least five.
    always_comb begin
        n_fields = r_fields;
        case (pos)
            16'd0:  n_fields.ver_ihl         = r_in_data;
            16'd1:  n_fields.tos             = r_in_data;
            16'd2:  n_fields.total_len[15:8] = r_in_data;
            16'd3:  n_fields.total_len[7:0]  = r_in_data;
            16'd4:  n_fields.ident[15:8]     = r_in_data;
            16'd5:  n_fields.ident[7:0]      = r_in_data;
            16'd6:  n_fields.frag[15:8]      = r_in_data;
            16'd7:  n_fields.frag[7:0]       = r_in_data;
            16'd8:  n_fields.ttl             = r_in_data;
            16'd9:  n_fields.proto           = r_in_data;
            16'd12: n_fields.src_addr[31:24] = r_in_data;
            16'd13: n_fields.src_addr[23:16] = r_in_data;
            16'd14: n_fields.src_addr[15:8]  = r_in_data;
            16'd15: n_fields.src_addr[7:0]   = r_in_data;
            16'd16: n_fields.dst_addr[31:24] = r_in_data;
            16'd17: n_fields.dst_addr[23:16] = r_in_data;
            16'd18: n_fields.dst_addr[15:8]  = r_in_data;
            16'd19: n_fields.dst_addr[7:0]   = r_in_data;
            default: ;
        endcase
        if (in_udp_hdr) begin
            case (udp_off)
                3'd0:    n_fields.src_port[15:8] = r_in_data;
                3'd1:    n_fields.src_port[7:0]  = r_in_data;
                3'd2:    n_fields.dst_port[15:8] = r_in_data;
                3'd3:    n_fields.dst_port[7:0]  = r_in_data;
                3'd4:    n_fields.udp_len[15:8]  = r_in_data;
                3'd5:    n_fields.udp_len[7:0]   = r_in_data;
                3'd7:    n_fields.udp_seen       = 1'b1;
                default: ;
            endcase
        end
        // The count stops at its top value on very long packets.
        n_byte_count = (r_byte_count != COUNT_MAX) ? r_byte_count + 16'd1 : r_byte_count;
    end

    // The checks see the state with the last byte already folded in.
    iuhp_verdict u_verdict (
        .i_fields      (n_fields),
        .i_byte_count  (n_byte_count),
        .i_max_len     (r_max_len),
        .o_status      (verdict),
        .o_payload_len (payload_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_PKT_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Packet state is cleared after each verdict, ready for the next packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 16'd0;
            r_fields     <= '0;
        end else if (proc_go) begin
            if (r_in_last) begin
                r_byte_count <= 16'd0;
                r_fields     <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_fields     <= n_fields;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && r_in_last) begin
            r_out_data <= {5'd0, payload_len, n_fields.ident, n_fields.tos,
                           n_fields.ttl, n_fields.dst_port, n_fields.src_port,
                           n_fields.dst_addr, n_fields.src_addr, verdict};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A finished packet leaves no state behind for the next one.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && r_in_last |=> r_byte_count == 16'd0 && r_fields == '0)
        else $error("packet state not cleared after last byte");

    // Inside a packet the count steps by one per byte until it saturates.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && !r_in_last && r_byte_count != COUNT_MAX
        |=> r_byte_count == $past(r_byte_count) + 16'd1)
        else $error("byte count did not advance");

    // Input back-pressure only comes from a last byte held while a verdict waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_in_last && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked verdict");

    // Payload length is only reported with a good verdict.
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2:0] != ST_OK |-> r_out_data[146:131] == 16'd0)
        else $error("payload length on a failed packet");

    // A verdict is written only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && r_in_last |-> !r_out_valid || m_axis_tready)
        else $error("verdict overwritten before it was taken");

endmodule

/* sv/iuhp_verdict.sv */
module iuhp_verdict (
    input  iuhp_pkg::t_pkt_fields i_fields,
    input  logic [15:0]           i_byte_count,
    input  logic [15:0]           i_max_len,
    output iuhp_pkg::t_status     o_status,
    output logic [15:0]           o_payload_len
);
    import iuhp_pkg::*;

    logic [3:0]  ihl;
    logic [15:0] hdr_len;
    logic [15:0] udp_expect;
    logic        udp_bad;

    assign ihl        = i_fields.ver_ihl[3:0];
    assign hdr_len    = {10'd0, ihl, 2'b00};
    assign udp_expect = i_fields.total_len - hdr_len;
    assign udp_bad    = !i_fields.udp_seen || (i_fields.udp_len < UDP_HDR_BYTES)
                        || (i_fields.total_len < hdr_len)
                        || (i_fields.udp_len != udp_expect);

    // Checks are prioritized; the first one that fails sets the status.
    always_comb begin
        o_payload_len = 16'd0;
        if (i_fields.total_len != i_byte_count) begin
            o_status = ST_LEN_MISM;
        end else if (i_fields.total_len > i_max_len) begin
            o_status = ST_TOO_LARGE;
        end else if (i_fields.ver_ihl[7:4] != IP_VERSION || ihl < MIN_IHL) begin
            o_status = ST_NOT_IPV4;
        end else if ((i_fields.frag & FRAG_MASK) != 16'd0) begin
            o_status = ST_FRAGMENTED;
        end else if (i_fields.proto != PROTO_UDP) begin
            o_status = ST_NOT_UDP;
        end else if (udp_bad) begin
            o_status = ST_BAD_UDPLEN;
        end else begin
            o_status      = ST_OK;
            o_payload_len = i_fields.udp_len - UDP_HDR_BYTES;
        end
    end

endmodule

/* tb/sv/ipv4_udp_header_parser_tb.sv */
`timescale 1ns / 1ps

module ipv4_udp_header_parser_tb;
    import iuhp_pkg::*;

    // The longest stretch without any handshake in a correct run is the long
    // receiver hold plus one idle burst. The limit leaves a wide margin on top.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    // These margins cover a verdict's path through the input and output registers.
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RESET_CYCLES   = 8;

    // One verdict as it travels on the result bus, lowest field last.
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] payload_len;
        logic [15:0] ident;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        t_status     status;
    } t_verdict;

    // Ways in which a generated packet departs from a clean UDP datagram.
    typedef enum int {
        FLAW_NONE,
        FLAW_TOTAL,
        FLAW_VERSION,
        FLAW_SMALL_IHL,
        FLAW_FRAG,
        FLAW_PROTO,
        FLAW_UDPLEN,
        FLAW_TRUNC,
        FLAW_SHORT,
        FLAW_PADDED,
        FLAW_NOISE
    } t_flaw;

    // How the free header fields of a generated packet are filled.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    // Tracks the parser's header state byte by byte and keeps the verdicts
    // that are still due, oldest first.
    class header_verdict_board;
        t_pkt_fields hdr;
        logic [15:0] nbytes;
        logic [15:0] mtu;
        t_verdict    verdicts_due[$];
        int          mismatches;

        function new();
            hdr        = '0;
            nbytes     = '0;
            mtu        = MAX_PKT_RESET;
            mismatches = 0;
        endfunction

        function void set_mtu(logic [15:0] value);
            mtu = value;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Captures one accepted byte; on the last byte of a packet the verdict
        // is worked out and queued, and the packet state is cleared.
        function void take_byte(logic [7:0] b, logic last);
            int       pos;
            int       hstart;
            int       off;
            t_verdict v;

            pos    = int'(nbytes);
            // The header length in force is the one captured before this byte.
            hstart = 4 * int'(hdr.ver_ihl[3:0]);
            case (pos)
                0:  hdr.ver_ihl          = b;
                1:  hdr.tos              = b;
                2:  hdr.total_len[15:8]  = b;
                3:  hdr.total_len[7:0]   = b;
                4:  hdr.ident[15:8]      = b;
                5:  hdr.ident[7:0]       = b;
                6:  hdr.frag[15:8]       = b;
                7:  hdr.frag[7:0]        = b;
                8:  hdr.ttl              = b;
                9:  hdr.proto            = b;
                12, 13, 14, 15: hdr.src_addr[8 * (15 - pos) +: 8] = b;
                16, 17, 18, 19: hdr.dst_addr[8 * (19 - pos) +: 8] = b;
                default: ;
            endcase
            // The UDP header starts right after the IP header and options.
            if (hstart >= 20 && pos >= hstart && pos < hstart + 8) begin
                off = pos - hstart;
                case (off)
                    0: hdr.src_port[15:8] = b;
                    1: hdr.src_port[7:0]  = b;
                    2: hdr.dst_port[15:8] = b;
                    3: hdr.dst_port[7:0]  = b;
                    4: hdr.udp_len[15:8]  = b;
                    5: hdr.udp_len[7:0]   = b;
                    7: hdr.udp_seen       = 1'b1;
                    default: ;
                endcase
            end
            if (nbytes != COUNT_MAX) begin
                nbytes = nbytes + 16'd1;
            end
            if (!last) begin
                return;
            end

            v = '0;
            if (hdr.total_len != nbytes) begin
                v.status = ST_LEN_MISM;
            end else if (hdr.total_len > mtu) begin
                v.status = ST_TOO_LARGE;
            end else if (hdr.ver_ihl[7:4] != IP_VERSION || hdr.ver_ihl[3:0] < MIN_IHL) begin
                v.status = ST_NOT_IPV4;
            end else if ((hdr.frag & FRAG_MASK) != '0) begin
                v.status = ST_FRAGMENTED;
            end else if (hdr.proto != PROTO_UDP) begin
                v.status = ST_NOT_UDP;
            end else if (!hdr.udp_seen || hdr.udp_len < UDP_HDR_BYTES
                         || int'(hdr.total_len) < hstart
                         || int'(hdr.udp_len) != int'(hdr.total_len) - hstart) begin
                v.status = ST_BAD_UDPLEN;
            end else begin
                v.status      = ST_OK;
                v.payload_len = hdr.udp_len - UDP_HDR_BYTES;
            end
            v.src_addr = hdr.src_addr;
            v.dst_addr = hdr.dst_addr;
            v.src_port = hdr.src_port;
            v.dst_port = hdr.dst_port;
            v.ttl      = hdr.ttl;
            v.tos      = hdr.tos;
            v.ident    = hdr.ident;
            verdicts_due.push_back(v);
            hdr    = '0;
            nbytes = '0;
        endfunction

        function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_verdict(t_verdict act);
            t_verdict exp_v;

            if (verdicts_due.size() == 0) begin
                $display("%0t verdict with none due: expected nothing, actual %h",
                         $realtime, act);
                mismatches++;
                return;
            end
            exp_v = verdicts_due.pop_front();
            field_check("status",          32'(exp_v.status),      32'(act.status));
            field_check("src_address",     exp_v.src_addr,         act.src_addr);
            field_check("dst_address",     exp_v.dst_addr,         act.dst_addr);
            field_check("src_port",        32'(exp_v.src_port),    32'(act.src_port));
            field_check("dst_port",        32'(exp_v.dst_port),    32'(act.dst_port));
            field_check("time_to_live",    32'(exp_v.ttl),         32'(act.ttl));
            field_check("type_of_service", 32'(exp_v.tos),         32'(act.tos));
            field_check("identification",  32'(exp_v.ident),       32'(act.ident));
            field_check("payload_length",  32'(exp_v.payload_len), 32'(act.payload_len));
            field_check("padding",         32'(exp_v.pad),         32'(act.pad));
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [15:0]             i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata;   // [7:0] data_byte
    logic                    s_axis_tlast;   // last_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [2:0] status, [34:3] src_address, [66:35] dst_address, [82:67] src_port,
    // [98:83] dst_port, [106:99] time_to_live, [114:107] type_of_service,
    // [130:115] identification, [146:131] payload_length, [151:147] zero
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    header_verdict_board board = new();

    // Idle controls for the sender and the receiver process.
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit rx_hold = 1'b0;
    int quiet_cycles;

    ipv4_udp_header_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Handshakes are sampled at the rising edge, before the block's own
    // registers update, so the values seen are the ones the block acted on.
    // A result is checked before a byte of the same edge is taken, so a
    // verdict can never be matched against one queued at that very edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we) begin
                board.set_mtu(i_cfg_wdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_verdict(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                board.take_byte(s_axis_tdata, s_axis_tlast);
            end
        end
    end

    // The receiver mostly accepts, stalls now and then in short bursts, and
    // once holds off for a long stretch while the sender keeps going, so that
    // the output register fills and the input side has to stall.
    initial begin
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // Ends the run if no item moves on either side for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("ipv4_udp_header_parser: mismatch");
        $finish;
    end

    function automatic logic [31:0] field_value(t_fill fill);
        case (fill)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            default:   return $urandom();
        endcase
    endfunction

    function automatic void push_be(ref logic [7:0] pkt[$], input logic [31:0] value,
                                    input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--) begin
            pkt.push_back(value[8 * k +: 8]);
        end
    endfunction

    // Builds one packet: a clean IPv4/UDP datagram, then damaged as asked.
    // An ihl of zero picks one at random, mostly the plain 20-byte header.
    function automatic void build_datagram(ref logic [7:0] pkt[$], input t_flaw flaw,
                                           input t_fill fill, input int ihl);
        int          hlen;
        int          paylen;
        int          n;
        logic [15:0] total;
        logic [15:0] ulen;
        logic [15:0] frag;
        logic [15:0] word;
        logic [7:0]  code;

        if (ihl == 0) begin
            ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        end
        hlen   = 4 * ihl;
        paylen = (fill == FILL_ZERO) ? 0 : (fill == FILL_ONES) ? 4 : $urandom_range(0, 4);
        ulen   = 16'(8 + paylen);
        total  = 16'(hlen) + ulen;
        case (fill)
            FILL_ZERO: frag = '0;
            FILL_ONES: frag = ~FRAG_MASK;
            default:   frag = $urandom_range(0, 1) ? ~FRAG_MASK : 16'h0000;
        endcase

        pkt.delete();
        pkt.push_back({IP_VERSION, 4'(ihl)});
        push_be(pkt, field_value(fill), 1);         // type of service
        push_be(pkt, {16'd0, total}, 2);
        push_be(pkt, field_value(fill), 2);         // identification
        push_be(pkt, {16'd0, frag}, 2);
        push_be(pkt, field_value(fill), 1);         // time to live
        pkt.push_back(PROTO_UDP);
        push_be(pkt, $urandom(), 2);                // header checksum, not checked
        push_be(pkt, field_value(fill), 4);
        push_be(pkt, field_value(fill), 4);
        repeat (hlen - 20) pkt.push_back(8'($urandom()));
        push_be(pkt, field_value(fill), 2);
        push_be(pkt, field_value(fill), 2);
        push_be(pkt, {16'd0, ulen}, 2);
        push_be(pkt, $urandom(), 2);
        repeat (paylen) pkt.push_back(8'($urandom()));

        case (flaw)
            FLAW_TOTAL: begin
                word   = 16'($urandom());
                pkt[2] = word[15:8];
                pkt[3] = word[7:0];
            end
            FLAW_VERSION: begin
                code = 8'($urandom_range(0, 14));
                if (code >= 8'(IP_VERSION)) begin
                    code++;
                end
                pkt[0][7:4] = code[3:0];
            end
            FLAW_SMALL_IHL: pkt[0][3:0] = 4'($urandom_range(0, 4));
            FLAW_FRAG: begin
                word = 16'($urandom()) & FRAG_MASK;
                if (word == '0) begin
                    word = 16'h0001;
                end
                pkt[6] = pkt[6] | word[15:8];
                pkt[7] = pkt[7] | word[7:0];
            end
            FLAW_PROTO: begin
                code = 8'($urandom_range(0, 254));
                if (code >= PROTO_UDP) begin
                    code++;
                end
                pkt[9] = code;
            end
            FLAW_UDPLEN: begin
                case ($urandom_range(0, 2))
                    0:       word = 16'($urandom_range(0, 7));
                    1:       word = $urandom_range(0, 1) ? ulen + 16'd1 : ulen - 16'd1;
                    default: word = 16'($urandom());
                endcase
                pkt[hlen + 4] = word[15:8];
                pkt[hlen + 5] = word[7:0];
            end
            FLAW_TRUNC: begin
                repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
            end
            FLAW_SHORT: begin
                // Once the cut keeps the length field, it is set to agree with the cut, so the
                // packet passes the length check but its UDP header is incomplete or absent.
                n = $urandom_range(1, hlen + 7);
                while (pkt.size() > n) void'(pkt.pop_back());
                if (n > 3) begin
                    word   = 16'(n);
                    pkt[2] = word[15:8];
                    pkt[3] = word[7:0];
                end
            end
            FLAW_PADDED: begin
                repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom()));
            end
            FLAW_NOISE: begin
                pkt.delete();
                repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom()));
            end
            default: ;
        endcase
    endfunction

    // Offers one item and returns at the edge where it is taken. The valid
    // stays high on return, so the next call can follow without a gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] pkt[$]);
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // The register is only written with the block idle: every verdict in,
    // then a settling wait for the pipeline to empty.
    task automatic write_mtu(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [7:0] pkt[$];
        int         npkts;
        t_flaw      flaw;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed packets at the reset limit of 1500 bytes. First clean
        // datagrams with all-zero and all-one fields and the longest header,
        // then one packet for each kind of damage.
        build_datagram(pkt, FLAW_NONE, FILL_ZERO, 5);
        send_packet(pkt);
        build_datagram(pkt, FLAW_NONE, FILL_ONES, 15);
        send_packet(pkt);
        for (int f = FLAW_TOTAL; f <= FLAW_NOISE; f++) begin
            build_datagram(pkt, t_flaw'(f), FILL_RANDOM, 0);
            send_packet(pkt);
        end
        // A single byte carries both the first and the last mark.
        pkt.delete();
        pkt.push_back({IP_VERSION, MIN_IHL});
        send_packet(pkt);
        // An ihl just below the minimum.
        build_datagram(pkt, FLAW_NONE, FILL_RANDOM, 5);
        pkt[0][3:0] = MIN_IHL - 4'd1;
        send_packet(pkt);

        // At the smallest limit a full datagram is too large, while a bare
        // 20-byte header fits and then fails for its missing UDP header.
        write_mtu(16'd20);
        build_datagram(pkt, FLAW_NONE, FILL_RANDOM, 5);
        send_packet(pkt);
        build_datagram(pkt, FLAW_NONE, FILL_ZERO, 5);
        while (pkt.size() > 20) void'(pkt.pop_back());
        pkt[2] = 8'd0;
        pkt[3] = 8'd20;
        send_packet(pkt);

        // Random traffic in four settings of the limit. Most packets are
        // clean datagrams with random content; the rest are damaged or noise.
        // The second setting brings the long receiver hold, the third a
        // pause of the sender until every verdict is in, and the last one
        // runs with no idling at all.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       write_mtu(MAX_PKT_RESET);
                1:       write_mtu(16'($urandom_range(20, 80)));
                2:       write_mtu(16'hFFFF);
                default: write_mtu(16'($urandom_range(30, 60)));
            endcase
            if (ph == 1) begin
                rx_hold = 1'b1;
            end
            if (ph == 3) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            npkts = 0;
            while (npkts < ((ph == 1) ? 3 : 2)) begin
                if (ph == 2 && npkts == 1) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (board.pending() != 0);
                end
                if ($urandom_range(0, 9) < 6) begin
                    flaw = FLAW_NONE;
                end else begin
                    flaw = t_flaw'($urandom_range(FLAW_TOTAL, FLAW_NOISE));
                end
                build_datagram(pkt, flaw, FILL_RANDOM, 0);
                send_packet(pkt);
                npkts++;
            end
        end

        // Let the last verdicts come out, then keep watching the output so that a
        // stray extra result would still be caught.
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("ipv4_udp_header_parser: match");
        end else begin
            $display("ipv4_udp_header_parser: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/iuhp_pkg.sv
sv/iuhp_verdict.sv
sv/ipv4_udp_header_parser.sv
tb/sv/ipv4_udp_header_parser_tb.sv
